FILE: src/interval_set_manager_unit_defines.svh
// ----------------------------------------------------------------------------
// Interval set manager assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef INTERVAL_SET_MANAGER_UNIT_DEFINES_SVH
`define INTERVAL_SET_MANAGER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ISM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("interval set manager: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ISM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("interval set manager: next-cycle check failed");

`endif

FILE: src/ism_pkg.sv
// ----------------------------------------------------------------------------
// Interval set manager package
// Request codes, status codes, cell commands and controller states.
// ----------------------------------------------------------------------------
package ism_pkg;

   typedef enum logic [2:0] {
      REQ_ALLOC   = 3'd0,
      REQ_CHECK   = 3'd1,
      REQ_RELEASE = 3'd2,
      REQ_LIST    = 3'd3,
      REQ_MERGE   = 3'd4
   } req_code_type;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_INVALID = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_ROTATE,
      CELL_TRIM,
      CELL_REMOVE,
      CELL_INSERT
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        split_any;
   } cell_cmd_type;

   typedef struct packed {
      logic valid;
      logic lt;       // start below request start
      logic after;    // start above request start
      logic split;    // request lies strictly inside
      logic ovl;      // overlaps request
      logic covered;  // fully inside request
      logic ge;       // end above request start
   } cell_flags_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_REMOVE,
      ST_INSERT,
      ST_RESP,
      ST_LIST,
      ST_FINISH
   } state_type;

endpackage

FILE: src/ism_cell.sv
// ----------------------------------------------------------------------------
// Interval set manager cell
// Holds one table entry and updates it from its neighbors on command.
// ----------------------------------------------------------------------------
module ism_cell #(
   parameter int COORD_BITS = 16,
   parameter int INDEX      = 0,
   parameter int CNT_BITS   = 5
) (
   input  logic                         clock,
   input  ism_pkg::cell_cmd_type        cmd,
   input  logic [CNT_BITS-1:0]          count,
   input  logic signed [COORD_BITS-1:0] req_s,
   input  logic signed [COORD_BITS-1:0] req_e,
   input  logic signed [COORD_BITS-1:0] left_start,
   input  logic signed [COORD_BITS-1:0] left_end,
   input  ism_pkg::cell_flags_type      left_flags,
   input  logic signed [COORD_BITS-1:0] right_start,
   input  logic signed [COORD_BITS-1:0] right_end,
   output logic signed [COORD_BITS-1:0] start_q,
   output logic signed [COORD_BITS-1:0] end_q,
   output ism_pkg::cell_flags_type      flags
);

   localparam logic [CNT_BITS-1:0] IDX = CNT_BITS'(INDEX);

   logic signed [COORD_BITS-1:0] start_ff, start_in;
   logic signed [COORD_BITS-1:0] end_ff, end_in;

   always_comb begin
      flags.valid   = IDX < count;
      flags.lt      = flags.valid && (start_ff < req_s);
      flags.after   = flags.valid && (start_ff > req_s);
      flags.split   = flags.valid && (start_ff < req_s) && (req_e < end_ff);
      flags.ovl     = flags.valid && (req_s < end_ff) && (start_ff < req_e);
      flags.covered = flags.valid && (req_s <= start_ff) && (end_ff <= req_e);
      flags.ge      = flags.valid && (end_ff > req_s);
   end

   always_comb begin
      start_in = start_ff;
      end_in   = end_ff;
      case (cmd.op)
         ism_pkg::CELL_ROTATE: begin
            start_in = right_start;
            end_in   = right_end;
         end
         ism_pkg::CELL_TRIM: begin
            if (cmd.split_any) begin
               if (flags.split) begin
                  end_in = req_s;
               end else if (left_flags.split) begin
                  start_in = req_e;
                  end_in   = left_end;
               end else if (left_flags.after) begin
                  start_in = left_start;
                  end_in   = left_end;
               end
            end else if (flags.ovl && !flags.covered) begin
               if (start_ff < req_s) begin
                  end_in = req_s;
               end else begin
                  start_in = req_e;
               end
            end
         end
         ism_pkg::CELL_REMOVE: begin
            if (flags.ge) begin
               start_in = right_start;
               end_in   = right_end;
            end
         end
         ism_pkg::CELL_INSERT: begin
            if (!flags.lt) begin
               if (left_flags.lt) begin
                  start_in = req_s;
                  end_in   = req_e;
               end else begin
                  start_in = left_start;
                  end_in   = left_end;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      end_ff   <= end_in;
   end

   assign start_q = start_ff;
   assign end_q   = end_ff;

endmodule

FILE: src/interval_set_manager_unit.sv
// ----------------------------------------------------------------------------
// Interval set manager unit
// Sorted table of disjoint half-open intervals held in a chain of cells.
// ----------------------------------------------------------------------------
// The table lives in a row of TABLE_DEPTH cells, one interval each, sorted
// by start. A word is taken only when the unit is idle. Check goes from
// decide to respond; an invalid range or a full table answers the same way.
// Allocate and release remove one stale entry per cycle, up to TABLE_DEPTH
// entries, and then respond (allocate inserts the new entry first). Both
// list requests rotate the whole chain once through cell 0, holding while a
// result stalls; a merged list adds a final result. An empty table answers
// a list straight from decide. Results leave through an output register, so
// each new result waits only for the previous one to go.
// ----------------------------------------------------------------------------
module interval_set_manager_unit #(
   parameter int TABLE_DEPTH = 16,
   parameter int COORD_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // range_start[15:0], range_end[31:16]
   input  logic [2:0]  req_tuser,   // req_type[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // out_start[15:0], out_end[31:16]
   output logic [3:0]  rsp_tuser,   // status[1:0], is_free[2], list_empty[3]
   output logic        rsp_tlast    // last
);

   localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_BITS = $clog2(TABLE_DEPTH);
   localparam int PW       = (COORD_BITS > 16) ? COORD_BITS : 16;
   localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(TABLE_DEPTH);
   localparam logic [IDX_BITS-1:0] LAST_IDX   = IDX_BITS'(TABLE_DEPTH - 1);

   // Port coordinates to internal width and back.
   function automatic logic [15:0] to_port(input logic [COORD_BITS-1:0] v);
      logic [PW-1:0] w;
      w = PW'(v);
      return w[15:0];
   endfunction

   logic [PW-1:0]                port_s_wide, port_e_wide;
   logic signed [COORD_BITS-1:0] port_s, port_e;

   assign port_s_wide = PW'(req_tdata[15:0]);
   assign port_e_wide = PW'(req_tdata[31:16]);
   assign port_s      = port_s_wide[COORD_BITS-1:0];
   assign port_e      = port_e_wide[COORD_BITS-1:0];

   // Control state.
   ism_pkg::state_type           state_ff, state_in;
   logic [2:0]                   type_ff, type_in;
   logic signed [COORD_BITS-1:0] s_ff, s_in, e_ff, e_in;
   logic [1:0]                   status_ff, status_in;
   logic                         free_ff, free_in, empty_ff, empty_in;
   logic [CNT_BITS-1:0]          count_ff, count_in;
   logic [IDX_BITS-1:0]          idx_ff, idx_in;
   logic signed [COORD_BITS-1:0] cs_ff, cs_in, ce_ff, ce_in;

   // Output register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [31:0]                  rsp_data_ff;
   logic [3:0]                   rsp_user_ff;
   logic                         rsp_last_ff;
   logic                         out_free, load;
   logic [COORD_BITS-1:0]        ld_start, ld_end;
   logic [1:0]                   ld_status;
   logic                         ld_free, ld_empty, ld_last;

   // Cell chain.
   ism_pkg::cell_cmd_type        cmd;
   logic signed [COORD_BITS-1:0] cell_start [TABLE_DEPTH];
   logic signed [COORD_BITS-1:0] cell_end   [TABLE_DEPTH];
   ism_pkg::cell_flags_type      cell_flags [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]       ovl_vec, cov_vec, split_vec;
   logic                         ovl_any, cov_any, split_any;

   localparam ism_pkg::cell_flags_type EDGE_FLAGS = '{
      valid: 1'b0, lt: 1'b1, after: 1'b0, split: 1'b0,
      ovl: 1'b0, covered: 1'b0, ge: 1'b0};

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      localparam int RIGHT = (i + 1) % TABLE_DEPTH;
      logic signed [COORD_BITS-1:0] l_start, l_end;
      ism_pkg::cell_flags_type      l_flags;

      if (i == 0) begin : g_edge
         assign l_start = '0;
         assign l_end   = '0;
         assign l_flags = EDGE_FLAGS;
      end else begin : g_link
         assign l_start = cell_start[i-1];
         assign l_end   = cell_end[i-1];
         assign l_flags = cell_flags[i-1];
      end

      ism_cell #(
         .COORD_BITS (COORD_BITS),
         .INDEX      (i),
         .CNT_BITS   (CNT_BITS)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .count       (count_ff),
         .req_s       (s_ff),
         .req_e       (e_ff),
         .left_start  (l_start),
         .left_end    (l_end),
         .left_flags  (l_flags),
         .right_start (cell_start[RIGHT]),
         .right_end   (cell_end[RIGHT]),
         .start_q     (cell_start[i]),
         .end_q       (cell_end[i]),
         .flags       (cell_flags[i])
      );

      assign ovl_vec[i]   = cell_flags[i].ovl;
      assign cov_vec[i]   = cell_flags[i].covered;
      assign split_vec[i] = cell_flags[i].split;
   end

   assign ovl_any   = |ovl_vec;
   assign cov_any   = |cov_vec;
   assign split_any = |split_vec;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ism_pkg::ST_IDLE);

   // Sequencer: next state, cell command and result load.
   always_comb begin
      logic invalid, in_range, want_emit, kill_any, is_merge;
      state_in      = state_ff;
      type_in       = type_ff;
      s_in          = s_ff;
      e_in          = e_ff;
      status_in     = status_ff;
      free_in       = free_ff;
      empty_in      = empty_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      cs_in         = cs_ff;
      ce_in         = ce_ff;
      cmd.op        = ism_pkg::CELL_HOLD;
      cmd.split_any = split_any;
      load          = 1'b0;
      ld_start      = '0;
      ld_end        = '0;
      ld_status     = status_ff;
      ld_free       = free_ff;
      ld_empty      = empty_ff;
      ld_last       = 1'b1;
      invalid       = (s_ff >= e_ff);
      in_range      = CNT_BITS'(idx_ff) < count_ff;
      is_merge      = (type_ff == ism_pkg::REQ_MERGE);
      kill_any      = (type_ff == ism_pkg::REQ_ALLOC) ? ovl_any : cov_any;
      if (is_merge) begin
         want_emit = in_range && (idx_ff != '0) && (ce_ff != cell_start[0]);
      end else begin
         want_emit = in_range;
      end

      case (state_ff)
         ism_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               type_in   = req_tuser;
               s_in      = port_s;
               e_in      = port_e;
               status_in = ism_pkg::STATUS_OK;
               free_in   = 1'b0;
               empty_in  = 1'b0;
               idx_in    = '0;
               // Drop unknown request codes without a result.
               if (req_tuser <= ism_pkg::REQ_MERGE) begin
                  state_in = ism_pkg::ST_DECIDE;
               end
            end
         end
         ism_pkg::ST_DECIDE: begin
            case (type_ff)
               ism_pkg::REQ_ALLOC: begin
                  if (invalid) begin
                     status_in = ism_pkg::STATUS_INVALID;
                     state_in  = ism_pkg::ST_RESP;
                  end else if (count_ff == FULL_COUNT && !ovl_any) begin
                     status_in = ism_pkg::STATUS_FULL;
                     state_in  = ism_pkg::ST_RESP;
                  end else begin
                     state_in = ism_pkg::ST_REMOVE;
                  end
               end
               ism_pkg::REQ_CHECK: begin
                  if (invalid) begin
                     status_in = ism_pkg::STATUS_INVALID;
                  end else begin
                     free_in = !ovl_any;
                  end
                  state_in = ism_pkg::ST_RESP;
               end
               ism_pkg::REQ_RELEASE: begin
                  if (invalid) begin
                     status_in = ism_pkg::STATUS_INVALID;
                     state_in  = ism_pkg::ST_RESP;
                  end else if (split_any && count_ff == FULL_COUNT) begin
                     status_in = ism_pkg::STATUS_FULL;
                     state_in  = ism_pkg::ST_RESP;
                  end else begin
                     // Trim partial overlaps, split the enclosing entry.
                     cmd.op = ism_pkg::CELL_TRIM;
                     if (split_any) begin
                        count_in = count_ff + 1'b1;
                     end
                     state_in = ism_pkg::ST_REMOVE;
                  end
               end
               ism_pkg::REQ_LIST, ism_pkg::REQ_MERGE: begin
                  if (count_ff == '0) begin
                     empty_in = 1'b1;
                     state_in = ism_pkg::ST_RESP;
                  end else begin
                     state_in = ism_pkg::ST_LIST;
                  end
               end
               default: begin
                  state_in = ism_pkg::ST_IDLE;
               end
            endcase
         end
         ism_pkg::ST_REMOVE: begin
            // Drop the first entry of the doomed block, one per cycle.
            if (kill_any) begin
               cmd.op   = ism_pkg::CELL_REMOVE;
               count_in = count_ff - 1'b1;
            end else if (type_ff == ism_pkg::REQ_ALLOC) begin
               state_in = ism_pkg::ST_INSERT;
            end else begin
               state_in = ism_pkg::ST_RESP;
            end
         end
         ism_pkg::ST_INSERT: begin
            cmd.op   = ism_pkg::CELL_INSERT;
            count_in = count_ff + 1'b1;
            state_in = ism_pkg::ST_RESP;
         end
         ism_pkg::ST_RESP: begin
            if (out_free) begin
               load     = 1'b1;
               state_in = ism_pkg::ST_IDLE;
            end
         end
         ism_pkg::ST_LIST: begin
            // Rotate the chain once; cell 0 shows entry idx.
            if (!want_emit || out_free) begin
               cmd.op = ism_pkg::CELL_ROTATE;
               idx_in = idx_ff + 1'b1;
               if (want_emit) begin
                  load      = 1'b1;
                  ld_status = ism_pkg::STATUS_OK;
                  ld_free   = 1'b0;
                  ld_empty  = 1'b0;
                  if (is_merge) begin
                     ld_start = cs_ff;
                     ld_end   = ce_ff;
                     ld_last  = 1'b0;
                  end else begin
                     ld_start = cell_start[0];
                     ld_end   = cell_end[0];
                     ld_last  = (CNT_BITS'(idx_ff) == count_ff - 1'b1);
                  end
               end
               if (in_range) begin
                  if (idx_ff == '0 || want_emit) begin
                     cs_in = cell_start[0];
                  end
                  ce_in = cell_end[0];
               end
               if (idx_ff == LAST_IDX) begin
                  idx_in   = '0;
                  state_in = is_merge ? ism_pkg::ST_FINISH : ism_pkg::ST_IDLE;
               end
            end
         end
         ism_pkg::ST_FINISH: begin
            if (out_free) begin
               load      = 1'b1;
               ld_status = ism_pkg::STATUS_OK;
               ld_free   = 1'b0;
               ld_empty  = 1'b0;
               ld_start  = cs_ff;
               ld_end    = ce_ff;
               state_in  = ism_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ism_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ism_pkg::ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff   <= type_in;
      s_ff      <= s_in;
      e_ff      <= e_in;
      status_ff <= status_in;
      free_ff   <= free_in;
      empty_ff  <= empty_in;
      cs_ff     <= cs_in;
      ce_ff     <= ce_in;
      if (load) begin
         rsp_data_ff <= {to_port(ld_end), to_port(ld_start)};
         rsp_user_ff <= {ld_empty, ld_free, ld_status};
         rsp_last_ff <= ld_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: src/ism_checker.sv
// ----------------------------------------------------------------------------
// Interval set manager checker
// Port-level properties of the interval set manager, bound to the top.
// ----------------------------------------------------------------------------
`include "interval_set_manager_unit_defines.svh"

module ism_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [2:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [3:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // A stalled result word holds.
   `ISM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

   // One request at a time: intake closes after a known request word is taken.
   `ISM_ASSERT_NXT(a_one_at_a_time, clock, reset, req_tvalid && req_tready && (req_tuser <= ism_pkg::REQ_MERGE), !req_tready)

   // An empty list answer is a single clean word.
   `ISM_ASSERT_IMP(a_empty_clean, clock, reset, rsp_tvalid && rsp_tuser[3], rsp_tlast && rsp_tuser[2:0] == 3'd0 && rsp_tdata == 32'd0)

   // An error status ends the request and carries no coordinates.
   `ISM_ASSERT_IMP(a_error_clean, clock, reset, rsp_tvalid && rsp_tuser[1:0] != ism_pkg::STATUS_OK, rsp_tlast && rsp_tdata == 32'd0 && !rsp_tuser[2] && !rsp_tuser[3])

endmodule

bind interval_set_manager_unit ism_checker u_ism_checker (.*);
